>>> src/pcrc_pkg.sv
// ----------------------------------------------------------------------------
// pcrc_pkg
// word types, register indexes and reset values for the point crop/transform
// ----------------------------------------------------------------------------
package pcrc_pkg;

    localparam int COORD_BITS = 24;
    localparam int COEF_BITS  = 16;
    localparam int ROW_BITS   = 3 * COEF_BITS;
    localparam int SHIFT_BITS = 24;
    localparam int RAD_BITS   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RAD  = 3'd6;

    localparam logic [ROW_BITS-1:0]   ROT_ROW0_RST = 48'd68719476736;
    localparam logic [ROW_BITS-1:0]   ROT_ROW1_RST = 48'd1073741824;
    localparam logic [ROW_BITS-1:0]   ROT_ROW2_RST = 48'd16384;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RST    = 24'd0;
    localparam logic [RAD_BITS-1:0]   MIN_RAD_RST  = 16'd300;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] pz;
        logic                         cloud_end;
    } point_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] wx;
        logic signed [COORD_BITS-1:0] wy;
        logic signed [COORD_BITS-1:0] wz;
        logic                         kept;
        logic                         last_out;
    } result_word_t;

endpackage

>>> src/point_cloud_range_crop_transform.sv
// ----------------------------------------------------------------------------
// point_cloud_range_crop_transform
// rotate and translate lidar points, dropping those inside the crop radius
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+---------------------
//   point    | start, busy, point                      | start && !busy
//   result   | result_strobe, result                   | strobe, one cycle
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | valid && ready
//
// one word per cycle; busy stays low so a point is taken on every start
// pipeline registers: input register, product register, result register
// each axis uses three 24x16 multipliers, the range check three squares
// reset clears the pipeline valids and loads the register defaults
// results go out on a one-cycle strobe; the receiver cannot stall them
// ----------------------------------------------------------------------------
module point_cloud_range_crop_transform #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pcrc_pkg::point_word_t             point,
    output logic                              result_strobe,
    output pcrc_pkg::result_word_t            result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pcrc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pcrc_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 2;
    localparam int R2_W   = 2 * RAD_BITS;

    logic [ROW_BITS-1:0]          rot0_reg, rot1_reg, rot2_reg;
    logic signed [SHIFT_BITS-1:0] sx_reg, sy_reg, sz_reg;
    logic [RAD_BITS-1:0]          rad_reg;

    point_word_t                  pt_reg;
    logic                         v0_reg, v1_reg, v2_reg;
    logic                         end1_reg;
    logic [SQ_W-1:0]              sqx_reg, sqy_reg, sqz_reg;
    logic [R2_W-1:0]              r2_reg;
    result_word_t                 res_reg;
    result_word_t                 res_next;

    logic signed [COORD_BITS-1:0] qx, qy, qz;
    logic signed [SQ_W-1:0]       sqx, sqy, sqz;
    logic [DIST_W-1:0]            dist2;
    logic                         near;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    assign sqx = pt_reg.px * pt_reg.px;
    assign sqy = pt_reg.py * pt_reg.py;
    assign sqz = pt_reg.pz * pt_reg.pz;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot0_reg <= ROT_ROW0_RST;
            rot1_reg <= ROT_ROW1_RST;
            rot2_reg <= ROT_ROW2_RST;
            sx_reg   <= SHIFT_RST;
            sy_reg   <= SHIFT_RST;
            sz_reg   <= SHIFT_RST;
            rad_reg  <= MIN_RAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROT_ROW0: rot0_reg <= cfg_data[ROW_BITS-1:0];
                CFG_ROT_ROW1: rot1_reg <= cfg_data[ROW_BITS-1:0];
                CFG_ROT_ROW2: rot2_reg <= cfg_data[ROW_BITS-1:0];
                CFG_SHIFT_X:  sx_reg   <= cfg_data[SHIFT_BITS-1:0];
                CFG_SHIFT_Y:  sy_reg   <= cfg_data[SHIFT_BITS-1:0];
                CFG_SHIFT_Z:  sz_reg   <= cfg_data[SHIFT_BITS-1:0];
                CFG_MIN_RAD:  rad_reg  <= cfg_data[RAD_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pt_reg <= point;
        end
        sqx_reg  <= sqx;
        sqy_reg  <= sqy;
        sqz_reg  <= sqz;
        r2_reg   <= rad_reg * rad_reg;
        end1_reg <= pt_reg.cloud_end;
        res_reg  <= res_next;
    end

    pcrc_axis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_x (
        .clk   (clk),
        .px    (pt_reg.px),
        .py    (pt_reg.py),
        .pz    (pt_reg.pz),
        .row   (rot0_reg),
        .shift (sx_reg),
        .q     (qx)
    );

    pcrc_axis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_y (
        .clk   (clk),
        .px    (pt_reg.px),
        .py    (pt_reg.py),
        .pz    (pt_reg.pz),
        .row   (rot1_reg),
        .shift (sy_reg),
        .q     (qy)
    );

    pcrc_axis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_z (
        .clk   (clk),
        .px    (pt_reg.px),
        .py    (pt_reg.py),
        .pz    (pt_reg.pz),
        .row   (rot2_reg),
        .shift (sz_reg),
        .q     (qz)
    );

    always_comb
    begin
        dist2 = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
        near  = dist2 < DIST_W'(r2_reg);
        res_next.last_out = end1_reg;
        if (near)
        begin
            res_next.wx   = '0;
            res_next.wy   = '0;
            res_next.wz   = '0;
            res_next.kept = 1'b0;
        end
        else
        begin
            res_next.wx   = qx;
            res_next.wy   = qy;
            res_next.wz   = qz;
            res_next.kept = 1'b1;
        end
    end

    assign result_strobe = v2_reg;
    assign result        = res_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 result_strobe)
        else $error("accepted point did not produce a result three cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start, 3))
        else $error("result strobe without an accepted point");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.kept) |->
            (result.wx == '0 && result.wy == '0 && result.wz == '0))
        else $error("dropped point carries nonzero coordinates");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (result.last_out == $past(point.cloud_end, 3)))
        else $error("end-of-cloud flag lost in the pipeline");

endmodule

>>> src/pcrc_axis.sv
// ----------------------------------------------------------------------------
// pcrc_axis
// one world axis: registered row products, then sum, round and saturate
// ----------------------------------------------------------------------------
module pcrc_axis #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic signed [pcrc_pkg::COORD_BITS-1:0] px,
    input  logic signed [pcrc_pkg::COORD_BITS-1:0] py,
    input  logic signed [pcrc_pkg::COORD_BITS-1:0] pz,
    input  logic [pcrc_pkg::ROW_BITS-1:0]          row,
    input  logic signed [pcrc_pkg::SHIFT_BITS-1:0] shift,
    output logic signed [pcrc_pkg::COORD_BITS-1:0] q
);
    import pcrc_pkg::*;

    localparam int PROD_W = COORD_BITS + COEF_BITS;
    localparam int SUM_A  = PROD_W + 2;
    localparam int SUM_B  = SHIFT_BITS + COEF_FRAC_BITS + 1;
    localparam int ACC_W  = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 1;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);

    logic signed [PROD_W-1:0]     prod0_reg, prod1_reg, prod2_reg;
    logic signed [SHIFT_BITS-1:0] shift_reg;
    logic signed [ACC_W-1:0]      acc;
    logic signed [ACC_W-1:0]      rnd;

    always_ff @(posedge clk)
    begin
        prod0_reg <= $signed(row[COEF_BITS-1:0]) * px;
        prod1_reg <= $signed(row[2*COEF_BITS-1:COEF_BITS]) * py;
        prod2_reg <= $signed(row[3*COEF_BITS-1:2*COEF_BITS]) * pz;
        shift_reg <= shift;
    end

    always_comb
    begin
        acc = ACC_W'(prod0_reg) + ACC_W'(prod1_reg) + ACC_W'(prod2_reg)
            + (ACC_W'(shift_reg) <<< COEF_FRAC_BITS) + HALF;
        rnd = acc >>> COEF_FRAC_BITS;
        if (rnd > MAXV)
        begin
            q = MAXV[COORD_BITS-1:0];
        end
        else if (rnd < MINV)
        begin
            q = MINV[COORD_BITS-1:0];
        end
        else
        begin
            q = rnd[COORD_BITS-1:0];
        end
    end

endmodule
